### hdl/ps2s1_pkg.sv
package ps2s1_pkg;

    localparam logic [7:0] KEY_PREFIX_EXT  = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT      = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT      = 7'h36;
    localparam logic [7:0] KEY_CAPS        = 8'h3A;
    localparam logic [7:0] KEY_NUM         = 8'h45;
    localparam logic [7:0] KEY_EXT_SLASH   = 8'h35;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_NONE       = 8'h00;
    localparam logic [7:0] CASE_BIT_FLIP   = 8'h20;
    localparam int         ROM_ADDR_W      = 9;

    typedef struct packed {
        logic shift;
        logic caps;
        logic num;
    } t_flags;

    typedef struct packed {
        logic go;
        logic ext;
        logic slash;
    } t_key_req;

    function automatic logic [7:0] pick4(
        input logic       tr,
        input logic       sh,
        input logic [7:0] us,
        input logic [7:0] us_sh,
        input logic [7:0] trk,
        input logic [7:0] trk_sh
    );
        logic [7:0] v;
        if (tr) begin
            v = sh ? trk_sh : trk;
        end else begin
            v = sh ? us_sh : us;
        end
        return v;
    endfunction

    // address: {layout, shift, code[6:0]}
    function automatic logic [7:0] rom_byte(input logic [ROM_ADDR_W-1:0] addr);
        logic       tr;
        logic       sh;
        logic [6:0] idx;
        logic [7:0] lc;
        logic [7:0] v;
        tr  = addr[8];
        sh  = addr[7];
        idx = addr[6:0];
        lc  = 8'h00;
        v   = 8'h00;
        case (idx)
            7'd1:  v = 8'h1B;
            7'd2:  v = pick4(tr, sh, 8'h31, 8'h21, 8'h31, 8'h21);
            7'd3:  v = pick4(tr, sh, 8'h32, 8'h40, 8'h32, 8'h22);
            7'd4:  v = pick4(tr, sh, 8'h33, 8'h23, 8'h33, 8'h00);
            7'd5:  v = pick4(tr, sh, 8'h34, 8'h24, 8'h34, 8'h24);
            7'd6:  v = pick4(tr, sh, 8'h35, 8'h25, 8'h35, 8'h25);
            7'd7:  v = pick4(tr, sh, 8'h36, 8'h5E, 8'h36, 8'h26);
            7'd8:  v = pick4(tr, sh, 8'h37, 8'h26, 8'h37, 8'h2F);
            7'd9:  v = pick4(tr, sh, 8'h38, 8'h2A, 8'h38, 8'h28);
            7'd10: v = pick4(tr, sh, 8'h39, 8'h28, 8'h39, 8'h29);
            7'd11: v = pick4(tr, sh, 8'h30, 8'h29, 8'h30, 8'h3D);
            7'd12: v = pick4(tr, sh, 8'h2D, 8'h5F, 8'h2A, 8'h3F);
            7'd13: v = pick4(tr, sh, 8'h3D, 8'h2B, 8'h2D, 8'h5F);
            7'd14: v = 8'h08;
            7'd15: v = 8'h09;
            7'd16: lc = 8'h71;
            7'd17: lc = 8'h77;
            7'd18: lc = 8'h65;
            7'd19: lc = 8'h72;
            7'd20: lc = 8'h74;
            7'd21: lc = 8'h79;
            7'd22: lc = 8'h75;
            7'd23: lc = 8'h69;
            7'd24: lc = 8'h6F;
            7'd25: lc = 8'h70;
            7'd26: v = pick4(tr, sh, 8'h5B, 8'h7B, 8'hF0, 8'hD0);
            7'd27: v = pick4(tr, sh, 8'h5D, 8'h7D, 8'hFC, 8'hDC);
            7'd28: v = 8'h0A;
            7'd30: lc = 8'h61;
            7'd31: lc = 8'h73;
            7'd32: lc = 8'h64;
            7'd33: lc = 8'h66;
            7'd34: lc = 8'h67;
            7'd35: lc = 8'h68;
            7'd36: lc = 8'h6A;
            7'd37: lc = 8'h6B;
            7'd38: lc = 8'h6C;
            7'd39: v = pick4(tr, sh, 8'h3B, 8'h3A, 8'hFE, 8'hDE);
            7'd40: v = pick4(tr, sh, 8'h27, 8'h22, 8'h69, 8'hDD);
            7'd41: v = pick4(tr, sh, 8'h60, 8'h7E, 8'h2C, 8'h3B);
            7'd43: v = pick4(tr, sh, 8'h5C, 8'h7C, 8'h3C, 8'h3E);
            7'd44: lc = 8'h7A;
            7'd45: lc = 8'h78;
            7'd46: lc = 8'h63;
            7'd47: lc = 8'h76;
            7'd48: lc = 8'h62;
            7'd49: lc = 8'h6E;
            7'd50: lc = 8'h6D;
            7'd51: v = pick4(tr, sh, 8'h2C, 8'h3C, 8'hF6, 8'hD6);
            7'd52: v = pick4(tr, sh, 8'h2E, 8'h3E, 8'hE7, 8'hC7);
            7'd53: v = pick4(tr, sh, 8'h2F, 8'h3F, 8'h2E, 8'h3A);
            7'd55: v = 8'h2A;
            7'd57: v = 8'h20;
            7'd69: v = 8'h37;
            7'd70: v = 8'h38;
            7'd71: v = 8'h39;
            7'd72: v = 8'h2D;
            7'd73: v = 8'h34;
            7'd74: v = 8'h35;
            7'd75: v = 8'h36;
            7'd76: v = 8'h2B;
            7'd77: v = 8'h31;
            7'd78: v = 8'h32;
            7'd79: v = 8'h33;
            7'd80: v = 8'h30;
            7'd81: v = 8'h2E;
            default: v = 8'h00;
        endcase
        if (lc != 8'h00) begin
            v = sh ? (lc - CASE_BIT_FLIP) : lc;
        end
        return v;
    endfunction

endpackage

### hdl/ps2s1_rom.sv
module ps2s1_rom (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [ps2s1_pkg::ROM_ADDR_W-1:0]    i_addr,
    output logic [7:0]                          o_data
);

    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= ps2s1_pkg::rom_byte(i_addr);
        end
    end

    assign o_data = r_data;

endmodule

### hdl/ps2s1_keystate.sv
module ps2s1_keystate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic [7:0]                          i_code,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    output ps2s1_pkg::t_flags                   o_flags,
    output ps2s1_pkg::t_key_req                 o_req,
    output logic [ps2s1_pkg::ROM_ADDR_W-1:0]    o_addr
);

    logic r_shift, r_caps, r_num, r_ext, r_layout;
    logic n_shift, n_caps, n_num, n_ext;
    logic is_shift;

    assign is_shift = (i_code[6:0] == ps2s1_pkg::KEY_LSHIFT)
                   || (i_code[6:0] == ps2s1_pkg::KEY_RSHIFT);

    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        n_num   = r_num;
        n_ext   = r_ext;
        o_req   = '0;
        if (i_code == ps2s1_pkg::KEY_PREFIX_EXT) begin
            n_ext = 1'b1;
        end else if (i_code[7]) begin
            if (is_shift) begin
                n_shift = 1'b0;
            end
            n_ext = 1'b0;
        end else if (is_shift) begin
            n_shift = 1'b1;
            n_ext   = 1'b0;
        end else if (i_code == ps2s1_pkg::KEY_CAPS) begin
            n_caps = ~r_caps;
            n_ext  = 1'b0;
        end else if (i_code == ps2s1_pkg::KEY_NUM) begin
            n_num = ~r_num;
            n_ext = 1'b0;
        end else begin
            o_req.go    = 1'b1;
            o_req.ext   = r_ext;
            o_req.slash = (i_code == ps2s1_pkg::KEY_EXT_SLASH);
            n_ext       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_num    <= 1'b1;
            r_ext    <= 1'b0;
            r_layout <= 1'b0;
        end else begin
            if (i_take) begin
                r_shift <= n_shift;
                r_caps  <= n_caps;
                r_num   <= n_num;
                r_ext   <= n_ext;
            end
            if (i_cfg_we) begin
                r_layout <= i_cfg_data;
            end
        end
    end

    assign o_flags.shift = r_shift;
    assign o_flags.caps  = r_caps;
    assign o_flags.num   = r_num;
    assign o_addr        = {r_layout, r_shift, i_code[6:0]};

endmodule

### hdl/ps2_set1_scancode_to_char.sv
// A byte taken in is registered into stage one with its ROM read, then its character into the output register.
// Throughput: one byte per cycle while a valid output is not held by i_out_stall.
// Bytes that only change flags, extended presses other than slash, and presses with an empty entry, give no result.
// Synchronous active-low reset: shift, caps lock and extended prefix cleared,
// num lock set, US layout selected, pipeline emptied.
module ps2_set1_scancode_to_char (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_scan_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_character,
    output logic       o_shift_active,
    output logic       o_caps_active,
    output logic       o_num_active,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    logic                                adv;
    logic                                take;
    ps2s1_pkg::t_flags                   flags;
    ps2s1_pkg::t_key_req                 req;
    logic [ps2s1_pkg::ROM_ADDR_W-1:0]    addr;
    logic [7:0]                          rom_data;
    logic [7:0]                          s1_char;

    logic                r_s1_vld;
    logic                r_s1_ext;
    logic                r_s1_slash;
    ps2s1_pkg::t_flags   r_s1_flags;
    logic                r_out_vld;
    logic [7:0]          r_out_char;
    ps2s1_pkg::t_flags   r_out_flags;

    assign adv        = !r_out_vld || !i_out_stall;
    assign take       = i_in_valid && adv;
    assign o_in_stall = !adv;

    ps2s1_keystate u_keystate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_code     (i_scan_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_flags    (flags),
        .o_req      (req),
        .o_addr     (addr)
    );

    ps2s1_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_addr (addr),
        .o_data (rom_data)
    );

    // pick the ROM byte, or slash / none for extended keys; swap case of ASCII letters under caps lock
    always_comb begin
        if (r_s1_ext) begin
            s1_char = r_s1_slash ? ps2s1_pkg::CHAR_SLASH : ps2s1_pkg::CHAR_NONE;
        end else begin
            s1_char = rom_data;
        end
        if (r_s1_flags.caps && (s1_char inside {[8'h41:8'h5A], [8'h61:8'h7A]})) begin
            s1_char = s1_char ^ ps2s1_pkg::CASE_BIT_FLIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= take && req.go;
            r_out_vld <= r_s1_vld && (s1_char != ps2s1_pkg::CHAR_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ext    <= req.ext;
            r_s1_slash  <= req.slash;
            r_s1_flags  <= flags;
            r_out_char  <= s1_char;
            r_out_flags <= r_s1_flags;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_character    = r_out_char;
    assign o_shift_active = r_out_flags.shift;
    assign o_caps_active  = r_out_flags.caps;
    assign o_num_active   = r_out_flags.num;

endmodule
